>>> src/edhf_pkg.sv
// ----------------------------------------------------------------------------
// edhf_pkg
// shared types and constants for the hysteresis event detector
// ----------------------------------------------------------------------------
package edhf_pkg;

	localparam int unsigned RegW  = 16;
	localparam int unsigned IdxW  = 3;
	localparam int unsigned DtW   = 15;
	localparam int unsigned AccW  = 17;

	// register indexes on the configuration port
	typedef enum logic [IdxW-1:0] {
		REG_ON_THRESHOLD  = 3'd0,
		REG_OFF_THRESHOLD = 3'd1,
		REG_CONFIRM_TIME  = 3'd2,
		REG_RELEASE_TIME  = 3'd3,
		REG_COOLDOWN_TIME = 3'd4
	} reg_idx_t;

	// reset values of the registers
	localparam logic [RegW-1:0] OnThresholdRst  = 16'd45875;
	localparam logic [RegW-1:0] OffThresholdRst = 16'd32768;
	localparam logic [RegW-1:0] ConfirmTimeRst  = 16'd200;
	localparam logic [RegW-1:0] ReleaseTimeRst  = 16'd500;
	localparam logic [RegW-1:0] CooldownTimeRst = 16'd1000;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_CAND   = 2'd1,
		PH_ACTIVE = 2'd2,
		PH_COOL   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [RegW-1:0] on_threshold;
		logic [RegW-1:0] off_threshold;
		logic [RegW-1:0] confirm_time_ms;
		logic [RegW-1:0] release_time_ms;
		logic [RegW-1:0] cooldown_time_ms;
	} cfg_t;

	typedef struct packed {
		phase_t fsm_state;
		logic   event_started;
		logic   event_ended;
	} result_t;

endpackage

>>> src/edhf_cfg_regs.sv
// ----------------------------------------------------------------------------
// edhf_cfg_regs
// configuration register file, write only, one register per index
// ----------------------------------------------------------------------------
module edhf_cfg_regs import edhf_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [IdxW-1:0] cfg_index,
	input  logic [RegW-1:0] cfg_data,
	output cfg_t            cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_threshold     <= OnThresholdRst;
			cfg_q.off_threshold    <= OffThresholdRst;
			cfg_q.confirm_time_ms  <= ConfirmTimeRst;
			cfg_q.release_time_ms  <= ReleaseTimeRst;
			cfg_q.cooldown_time_ms <= CooldownTimeRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ON_THRESHOLD:  cfg_q.on_threshold     <= cfg_data;
				REG_OFF_THRESHOLD: cfg_q.off_threshold    <= cfg_data;
				REG_CONFIRM_TIME:  cfg_q.confirm_time_ms  <= cfg_data;
				REG_RELEASE_TIME:  cfg_q.release_time_ms  <= cfg_data;
				REG_COOLDOWN_TIME: cfg_q.cooldown_time_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/edhf_core.sv
// ----------------------------------------------------------------------------
// edhf_core
// phase machine with confirm, release and cooldown timers
// ----------------------------------------------------------------------------
module edhf_core import edhf_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  cfg_t            cfg,
	input  logic [RegW-1:0] probability,
	input  logic [DtW-1:0]  dt,
	output result_t         res
);

	phase_t          phase_q, phase_d;
	logic [AccW-1:0] confirm_q, confirm_d;
	logic [AccW-1:0] release_q, release_d;
	logic [AccW-1:0] cool_q, cool_d;
	logic            started, ended;

	logic [AccW-1:0] dt_ext;
	logic [AccW-1:0] confirm_sum;
	logic [AccW-1:0] release_sum;
	logic            above_on;
	logic            below_off;
	logic            confirm_done;
	logic            release_done;
	logic            cool_done;

	// shared adders and compares
	always_comb begin
		dt_ext       = {{(AccW-DtW){1'b0}}, dt};
		confirm_sum  = confirm_q + dt_ext;
		release_sum  = release_q + dt_ext;
		above_on     = probability >= cfg.on_threshold;
		below_off    = probability <= cfg.off_threshold;
		confirm_done = confirm_sum >= {1'b0, cfg.confirm_time_ms};
		release_done = release_sum >= {1'b0, cfg.release_time_ms};
		cool_done    = dt_ext >= cool_q;
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE:   if (above_on) phase_d = PH_CAND;
			PH_CAND: begin
				if (!above_on) phase_d = PH_IDLE;
				else if (confirm_done) phase_d = PH_ACTIVE;
			end
			PH_ACTIVE: if (below_off && release_done) phase_d = PH_COOL;
			PH_COOL:   if (cool_done) phase_d = PH_IDLE;
			default:   phase_d = PH_IDLE;
		endcase
	end

	// timers and event pulses
	always_comb begin
		confirm_d = '0;
		release_d = '0;
		cool_d    = cool_q;
		started   = 1'b0;
		ended     = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (above_on) confirm_d = dt_ext;
			end
			PH_CAND: begin
				if (above_on && !confirm_done) confirm_d = confirm_sum;
				started = above_on && confirm_done;
			end
			PH_ACTIVE: begin
				if (below_off) begin
					if (release_done) begin
						cool_d = {1'b0, cfg.cooldown_time_ms};
						ended  = 1'b1;
					end else begin
						release_d = release_sum;
					end
				end
			end
			PH_COOL: begin
				cool_d = cool_done ? '0 : cool_q - dt_ext;
			end
			default: ;
		endcase
	end

	// state registers, updated once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			confirm_q <= '0;
			release_q <= '0;
			cool_q    <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			confirm_q <= confirm_d;
			release_q <= release_d;
			cool_q    <= cool_d;
		end
	end

	assign res.fsm_state     = phase_d;
	assign res.event_started = started;
	assign res.event_ended   = ended;

endmodule

>>> src/event_detect_hysteresis_fsm.sv
// ----------------------------------------------------------------------------
// event_detect_hysteresis_fsm
// event detector with hysteresis, confirmation, release and cooldown
// ----------------------------------------------------------------------------
// Takes one request per clock while in_stall is low and returns exactly one
// result per request. A request is registered on entry. The phase machine,
// its timers and the output register load together as the request advances
// out of the input register, which holds it while the output is stalled.
// Sustained rate is one request per cycle while the output is not stalled,
// set by the phase update, whose timer add and compare sit between the input
// and output registers. A stalled output holds its result while the input
// register still takes one more request. Negative elapsed times count as
// zero. Configuration is written through a plain write port and should only
// change while no request is in flight.
// ----------------------------------------------------------------------------
module event_detect_hysteresis_fsm import edhf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [IdxW-1:0]    cfg_index,
	input  logic [RegW-1:0]    cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [RegW-1:0]    probability,
	input  logic signed [15:0] elapsed_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         fsm_state,
	output logic               event_started,
	output logic               event_ended
);

	cfg_t            cfg;
	result_t         res;
	logic            valid_s1;
	logic [RegW-1:0] probability_s1;
	logic [DtW-1:0]  dt_s1;
	logic            out_valid_q;
	result_t         res_q;
	logic            out_free;
	logic            advance;
	logic            in_take;

	edhf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake control
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	// input register, negative time clamped to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			probability_s1 <= probability;
			dt_s1          <= elapsed_ms[15] ? '0 : elapsed_ms[DtW-1:0];
		end
	end

	edhf_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.cfg         (cfg),
		.probability (probability_s1),
		.dt          (dt_s1),
		.res         (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign fsm_state     = res_q.fsm_state;
	assign event_started = res_q.event_started;
	assign event_ended   = res_q.event_ended;

endmodule
